// ===== rtl/dmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpd_pkg
// Types and constants for the debounced multi-press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dmpd_pkg;

   localparam int CFG_WIDTH      = 16;
   localparam int CSR_IDX_WIDTH  = 8;
   localparam int REPORT_WIDTH   = 22;
   localparam int HOLD_WIDTH     = 14;
   localparam int SCALE_WIDTH    = 14;

   localparam logic [9:0]            CLEAR_DELAY_MS = 10'd500;
   localparam logic [SCALE_WIDTH-1:0] HOLD_SCALE    = 14'd10000;
   localparam logic [HOLD_WIDTH-1:0] HOLD_WRAP      = 14'd9999;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET    = 16'd50;
   localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET     = 16'd350;
   localparam logic [CFG_WIDTH-1:0] HOLD_THRESH_RESET = 16'd500;
   localparam logic [CFG_WIDTH-1:0] HOLD_UPDATE_RESET = 16'd100;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DEBOUNCE    = 8'd0,
      CSR_TIMEOUT     = 8'd1,
      CSR_HOLD_THRESH = 8'd2,
      CSR_HOLD_UPDATE = 8'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_RELEASED       = 3'd0,
      PH_MAYBE_PRESSED  = 3'd1,
      PH_PRESSED        = 3'd2,
      PH_MAYBE_RELEASED = 3'd3,
      PH_HOLD           = 3'd4,
      PH_MAYBE_UNHOLD   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ms;
      logic [CFG_WIDTH-1:0] multi_press_timeout_ms;
      logic [CFG_WIDTH-1:0] hold_threshold_ms;
      logic [CFG_WIDTH-1:0] hold_update_ms;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/dmpd_if.sv =====
// ----------------------------------------------------------------------------
// dmpd interfaces
// Sample, report and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmpd_req_if #(parameter int TIME_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [TIME_WIDTH-1:0] now_ms;
   logic                  pin_level;

   modport source (output valid, output now_ms, output pin_level, input ready);
   modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface

interface dmpd_rsp_if;
   import dmpd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [REPORT_WIDTH-1:0] report_value;

   modport source (output valid, output report_value, input ready);
   modport sink   (input valid, input report_value, output ready);
endinterface

interface dmpd_csr_if;
   import dmpd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_WIDTH-1:0] index;
   logic [CFG_WIDTH-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmpd_core.sv =====
// ----------------------------------------------------------------------------
// dmpd_core
// Button phases: debounce, press tally, hold reports, one sample a cycle on fire.
// ----------------------------------------------------------------------------
`default_nettype none

module dmpd_core
   import dmpd_pkg::*;
#(
   parameter int MAX_PRESSES = 255,
   parameter int TIME_WIDTH  = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire logic [TIME_WIDTH-1:0]   now_ms,
   input  wire logic                    pin_level,
   input  wire cfg_type                 cfg,
   output logic                         res_valid,
   output logic [REPORT_WIDTH-1:0]      res_value
);

   localparam int PW = $clog2(MAX_PRESSES + 1);
   localparam int MW = PW + 1 + SCALE_WIDTH;
   localparam int RW = (MW > REPORT_WIDTH) ? MW : REPORT_WIDTH;
   localparam logic [PW-1:0] PRESS_MAX = PW'(MAX_PRESSES);

   phase_type             phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;
   logic [PW-1:0]         press_ff, press_in;
   logic [HOLD_WIDTH-1:0] hold_ff, hold_in;
   logic                  clear_ff, clear_in;

   logic [TIME_WIDTH-1:0] elapsed;
   logic [TIME_WIDTH-1:0] deb, tmo, thr, upd;
   logic [HOLD_WIDTH-1:0] hold_next;
   logic [RW-1:0]         hold_report;

   always_comb begin
      elapsed   = now_ms - start_ff;
      deb       = TIME_WIDTH'(cfg.debounce_ms);
      tmo       = TIME_WIDTH'(cfg.multi_press_timeout_ms);
      thr       = TIME_WIDTH'(cfg.hold_threshold_ms);
      upd       = TIME_WIDTH'(cfg.hold_update_ms);
      // wrap the hold count back to one once it reaches the limit
      hold_next = (hold_ff + 1'b1 >= HOLD_WRAP) ? HOLD_WIDTH'(1) : hold_ff + 1'b1;
      hold_report = (RW'(press_ff) + RW'(1)) * RW'(HOLD_SCALE) + RW'(hold_next);
   end

   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      press_in  = press_ff;
      hold_in   = hold_ff;
      clear_in  = clear_ff;
      res_valid = 1'b0;
      res_value = '0;
      if (fire) begin
         unique case (phase_ff)
            PH_RELEASED: begin
               if (pin_level) begin
                  phase_in = PH_MAYBE_PRESSED;
                  start_in = now_ms;
               end else if (press_ff != '0 && elapsed > tmo) begin
                  res_valid = 1'b1;
                  res_value = REPORT_WIDTH'(press_ff);
                  press_in  = '0;
                  start_in  = now_ms;
                  clear_in  = 1'b1;
               end else if (clear_ff && elapsed > TIME_WIDTH'(CLEAR_DELAY_MS)) begin
                  res_valid = 1'b1;
                  clear_in  = 1'b0;
               end
            end
            PH_MAYBE_PRESSED: begin
               if (!pin_level && elapsed < deb) begin
                  phase_in = PH_RELEASED;
               end else if (elapsed > deb) begin
                  phase_in = PH_PRESSED;
               end
            end
            PH_PRESSED: begin
               if (!pin_level) begin
                  phase_in = PH_MAYBE_RELEASED;
                  start_in = now_ms;
               end else if (elapsed > thr) begin
                  phase_in = PH_HOLD;
               end
            end
            PH_MAYBE_RELEASED: begin
               if (pin_level && elapsed < deb) begin
                  phase_in = PH_PRESSED;
               end else if (elapsed > deb) begin
                  if (press_ff < PRESS_MAX) begin
                     press_in = press_ff + 1'b1;
                  end
                  phase_in = PH_RELEASED;
               end
            end
            PH_HOLD: begin
               if (!pin_level) begin
                  phase_in = PH_MAYBE_UNHOLD;
                  start_in = now_ms;
               end else if (elapsed > upd) begin
                  hold_in   = hold_next;
                  res_valid = 1'b1;
                  res_value = hold_report[REPORT_WIDTH-1:0];
                  start_in  = now_ms;
               end
            end
            PH_MAYBE_UNHOLD: begin
               if (pin_level && elapsed < deb) begin
                  phase_in = PH_HOLD;
               end else if (elapsed >= deb) begin
                  phase_in  = PH_RELEASED;
                  press_in  = '0;
                  hold_in   = '0;
                  res_valid = 1'b1;
               end
            end
            default: begin
               phase_in = PH_RELEASED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASED;
         start_ff <= '0;
         press_ff <= '0;
         hold_ff  <= '0;
         clear_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         press_ff <= press_in;
         hold_ff  <= hold_in;
         clear_ff <= clear_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/debounced_multi_press_detector_unit.sv =====
// A sample waits in the input register until the phase machine takes it; its
// report, if any, is registered. One sample a cycle unless the report stalls.
// A stalled report holds the output register; a second pending item stalls req.
// Reset (synchronous, active high) empties both registers, restores the default
// register values and returns the machine to released with a clear pending.
// ----------------------------------------------------------------------------
// debounced_multi_press_detector_unit
// Input register, phase machine, report register and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_multi_press_detector_unit
   import dmpd_pkg::*;
#(
   parameter int MAX_PRESSES = 255,
   parameter int TIME_WIDTH  = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   dmpd_req_if.sink    req_ch,
   dmpd_rsp_if.source  rsp_ch,
   dmpd_csr_if.sink    csr_ch
);

   cfg_type cfg_ff, cfg_in;

   logic                    in_valid_ff, in_valid_in;
   logic [TIME_WIDTH-1:0]   in_now_ff;
   logic                    in_level_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [REPORT_WIDTH-1:0] out_value_ff;

   logic                    advance;
   logic                    res_valid;
   logic [REPORT_WIDTH-1:0] res_value;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DEBOUNCE:    cfg_in.debounce_ms            = csr_ch.data;
            CSR_TIMEOUT:     cfg_in.multi_press_timeout_ms = csr_ch.data;
            CSR_HOLD_THRESH: cfg_in.hold_threshold_ms      = csr_ch.data;
            CSR_HOLD_UPDATE: cfg_in.hold_update_ms         = csr_ch.data;
            default:         cfg_in = cfg_ff;
         endcase
      end
      in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !advance);
      out_valid_in = advance ? res_valid : (out_valid_ff && !rsp_ch.ready);
   end

   dmpd_core #(
      .MAX_PRESSES(MAX_PRESSES),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .now_ms   (in_now_ff),
      .pin_level(in_level_ff),
      .cfg      (cfg_ff),
      .res_valid(res_valid),
      .res_value(res_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms            <= DEBOUNCE_RESET;
         cfg_ff.multi_press_timeout_ms <= TIMEOUT_RESET;
         cfg_ff.hold_threshold_ms      <= HOLD_THRESH_RESET;
         cfg_ff.hold_update_ms         <= HOLD_UPDATE_RESET;
         in_valid_ff                   <= 1'b0;
         out_valid_ff                  <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture a new item and the report without reset
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_now_ff   <= req_ch.now_ms;
         in_level_ff <= req_ch.pin_level;
      end
      if (advance && res_valid) begin
         out_value_ff <= res_value;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.report_value = out_value_ff;

   a_no_result_without_fire: assert property (@(posedge clock) disable iff (reset)
      !advance |-> !res_valid)
      else $error("core produced a report without processing an item");

   a_no_report_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid) |-> (!out_valid_ff || rsp_ch.ready))
      else $error("pending report overwritten");

   a_full_input_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_ch.ready)
      else $error("input register taken while still holding an item");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the debounced multi-press detector. Timestamped pin
// samples go through a press-report scoreboard that tracks its own copy of the
// button phase, tallies and registers. Every report is checked in order.
// ----------------------------------------------------------------------------

module tb;
   import dmpd_pkg::*;

   localparam int MAX_PRESSES     = 255;
   localparam int TIME_WIDTH      = 32;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FIRST_UNMAPPED = 8'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TOP_INDEX      = 8'hFF;

   class press_report_board #(int unsigned PRESS_LIMIT = 255);
      cfg_type                 regs;
      phase_type               phase;
      logic [31:0]             phase_start;
      int unsigned             presses;
      logic [HOLD_WIDTH-1:0]   holds;
      bit                      clear_due;
      logic [REPORT_WIDTH-1:0] expected_reports[$];
      int unsigned             samples, checked, hold_reports, hold_wraps;
      int unsigned             peak_presses, mismatches;

      function new();
         regs.debounce_ms            = DEBOUNCE_RESET;
         regs.multi_press_timeout_ms = TIMEOUT_RESET;
         regs.hold_threshold_ms      = HOLD_THRESH_RESET;
         regs.hold_update_ms         = HOLD_UPDATE_RESET;
         phase       = PH_RELEASED;
         phase_start = '0;
         presses     = 0;
         holds       = '0;
         clear_due   = 1'b1;
      endfunction

      function void write_reg(logic [CSR_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
         case (idx)
            CSR_DEBOUNCE:    regs.debounce_ms            = value;
            CSR_TIMEOUT:     regs.multi_press_timeout_ms = value;
            CSR_HOLD_THRESH: regs.hold_threshold_ms      = value;
            CSR_HOLD_UPDATE: regs.hold_update_ms         = value;
            default: ;
         endcase
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("report check failed: %s", msg);
      endfunction

      // Advance the button phase by one sample, queue the report it causes.
      function void note_sample(logic [31:0] now, logic level);
         logic [31:0] elapsed;
         bit          fire;
         int unsigned val;
         elapsed = now - phase_start;
         fire    = 1'b0;
         val     = 0;
         samples++;
         case (phase)
            PH_RELEASED: begin
               if (level) begin
                  phase       = PH_MAYBE_PRESSED;
                  phase_start = now;
               end else if (presses != 0 && elapsed > regs.multi_press_timeout_ms) begin
                  val         = presses;
                  fire        = 1'b1;
                  presses     = 0;
                  phase_start = now;
                  clear_due   = 1'b1;
               end else if (clear_due && elapsed > CLEAR_DELAY_MS) begin
                  fire      = 1'b1;
                  clear_due = 1'b0;
               end
            end
            PH_MAYBE_PRESSED: begin
               if (!level && elapsed < regs.debounce_ms) phase = PH_RELEASED;
               else if (elapsed > regs.debounce_ms) phase = PH_PRESSED;
            end
            PH_PRESSED: begin
               if (!level) begin
                  phase       = PH_MAYBE_RELEASED;
                  phase_start = now;
               end else if (elapsed > regs.hold_threshold_ms) begin
                  phase = PH_HOLD;
               end
            end
            PH_MAYBE_RELEASED: begin
               if (level && elapsed < regs.debounce_ms) begin
                  phase = PH_PRESSED;
               end else if (elapsed > regs.debounce_ms) begin
                  if (presses < PRESS_LIMIT) presses++;
                  if (presses > peak_presses) peak_presses = presses;
                  phase = PH_RELEASED;
               end
            end
            PH_HOLD: begin
               if (!level) begin
                  phase       = PH_MAYBE_UNHOLD;
                  phase_start = now;
               end else if (elapsed > regs.hold_update_ms) begin
                  holds = holds + 1'b1;
                  if (holds >= HOLD_WRAP) begin
                     holds = HOLD_WIDTH'(1);
                     hold_wraps++;
                  end
                  val         = (presses + 1) * HOLD_SCALE + holds;
                  fire        = 1'b1;
                  phase_start = now;
                  hold_reports++;
               end
            end
            PH_MAYBE_UNHOLD: begin
               if (level && elapsed < regs.debounce_ms) begin
                  phase = PH_HOLD;
               end else if (elapsed >= regs.debounce_ms) begin
                  phase   = PH_RELEASED;
                  presses = 0;
                  holds   = '0;
                  fire    = 1'b1;
               end
            end
            default: phase = PH_RELEASED;
         endcase
         if (fire) expected_reports.push_back(val[REPORT_WIDTH-1:0]);
      endfunction

      function void check_report(logic [REPORT_WIDTH-1:0] got);
         logic [REPORT_WIDTH-1:0] want;
         checked++;
         if (expected_reports.size() == 0) begin
            flag($sformatf("unexpected report %0d", got));
         end else begin
            want = expected_reports.pop_front();
            if (got !== want) flag($sformatf("expected %0d, got %0d", want, got));
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void drop_leftovers();
         while (expected_reports.size() != 0)
            flag($sformatf("report %0d never arrived", expected_reports.pop_front()));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   bit          idling;
   logic [31:0] stamp;
   cfg_type     knobs;
   int unsigned hold_off_asks;

   press_report_board #(MAX_PRESSES) board;

   dmpd_req_if #(.TIME_WIDTH(TIME_WIDTH)) req_if ();
   dmpd_rsp_if                            rsp_if ();
   dmpd_csr_if                            csr_if ();

   debounced_multi_press_detector_unit #(
      .MAX_PRESSES(MAX_PRESSES),
      .TIME_WIDTH (TIME_WIDTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if.sink),
      .rsp_ch(rsp_if.source),
      .csr_ch(csr_if.sink)
   );

   always #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("debounced_multi_press_detector_unit regression: fail");
      $finish;
   end

   // Report side: check on handshake, then pick next ready (stall, hold-off or take).
   initial begin
      int unsigned hold_left, asks_seen;
      hold_left = 0;
      asks_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) board.check_report(rsp_if.report_value);
         if (hold_off_asks != asks_seen) begin
            asks_seen = hold_off_asks;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !(idling && $urandom_range(99) < 34);
         end
      end
   end

   task automatic sample_pin(input logic [31:0] at_ms, input logic level);
      if (idling) begin
         while ($urandom_range(99) < 34) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid     <= 1'b1;
      req_if.now_ms    <= at_ms;
      req_if.pin_level <= level;
      do @(posedge clock); while (!req_if.ready);
      board.note_sample(at_ms, level);
   endtask

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      board.write_reg(idx, value);
      case (idx)
         CSR_DEBOUNCE:    knobs.debounce_ms            = value;
         CSR_TIMEOUT:     knobs.multi_press_timeout_ms = value;
         CSR_HOLD_THRESH: knobs.hold_threshold_ms      = value;
         CSR_HOLD_UPDATE: knobs.hold_update_ms         = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CFG_WIDTH-1:0] deb, input logic [CFG_WIDTH-1:0] tmo,
                            input logic [CFG_WIDTH-1:0] thr, input logic [CFG_WIDTH-1:0] upd,
                            input bit poke_unmapped);
      write_csr(CSR_DEBOUNCE, deb);
      write_csr(CSR_TIMEOUT, tmo);
      write_csr(CSR_HOLD_THRESH, thr);
      write_csr(CSR_HOLD_UPDATE, upd);
      if (poke_unmapped) begin
         write_csr(CSR_TOP_INDEX, CFG_WIDTH'($urandom));
         write_csr(CSR_IDX_WIDTH'($urandom_range(CSR_FIRST_UNMAPPED, CSR_TOP_INDEX - 1)),
                   CFG_WIDTH'($urandom));
      end
      csr_if.valid <= 1'b0;
   endtask

   // Drop valid, wait for outstanding reports, then let the pipeline empty.
   task automatic settle();
      int unsigned waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      board.drop_leftovers();
   endtask

   // Gap near a window edge mostly, else up to half again past it, else up to 200.
   function automatic logic [31:0] near(input logic [31:0] w);
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 7) begin
         if (w == 0) return $urandom_range(1);
         return w + $urandom_range(2) - 1;
      end
      if (pick < 9) return $urandom_range(w + w / 2 + 1);
      return $urandom_range(200);
   endfunction

   function automatic logic [31:0] below(input logic [31:0] w);
      return (w == 0) ? 32'd0 : $urandom_range(w - 1);
   endfunction

   task automatic press_edge();
      sample_pin(stamp, 1'b1);
      if ($urandom_range(3) == 0) begin
         stamp += below(knobs.debounce_ms);
         sample_pin(stamp, 1'b0);
         stamp += $urandom_range(5);
         sample_pin(stamp, 1'b1);
      end
      stamp += near(knobs.debounce_ms);
      sample_pin(stamp, 1'b1);
      stamp += $urandom_range(1, 3);
      sample_pin(stamp, 1'b1);
   endtask

   task automatic release_edge();
      stamp += $urandom_range(1, 20);
      sample_pin(stamp, 1'b0);
      if ($urandom_range(3) == 0) begin
         stamp += below(knobs.debounce_ms);
         sample_pin(stamp, 1'b1);
         stamp += $urandom_range(1, 10);
         sample_pin(stamp, 1'b0);
      end
      stamp += near(knobs.debounce_ms);
      sample_pin(stamp, 1'b0);
      stamp += $urandom_range(2);
      sample_pin(stamp, 1'b0);
   endtask

   task automatic quiet_spell();
      int unsigned pick;
      repeat ($urandom_range(1, 3)) begin
         pick = $urandom_range(7);
         if (pick < 3) stamp += near(knobs.multi_press_timeout_ms);
         else if (pick < 5) stamp += near(CLEAR_DELAY_MS);
         else if (pick < 7) stamp += $urandom_range(50);
         else stamp += $urandom;
         sample_pin(stamp, 1'b0);
      end
   endtask

   // Mostly well-formed taps and holds with random timing, plus some raw noise.
   task automatic random_gestures(input int unsigned items);
      int unsigned goal, pick;
      goal = board.samples + items;
      while (board.samples < goal) begin
         pick = $urandom_range(19);
         if (pick < 7) begin
            repeat ($urandom_range(1, 4)) begin
               press_edge();
               release_edge();
            end
            quiet_spell();
         end else if (pick < 12) begin
            press_edge();
            stamp += near(knobs.hold_threshold_ms);
            sample_pin(stamp, 1'b1);
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(5) == 0) begin
                  stamp += $urandom_range(1, 5);
                  sample_pin(stamp, 1'b0);
                  stamp += below(knobs.debounce_ms);
                  sample_pin(stamp, 1'b1);
               end
               stamp += near(knobs.hold_update_ms);
               sample_pin(stamp, 1'b1);
            end
            release_edge();
         end else if (pick < 15) begin
            repeat ($urandom_range(1, 6)) begin
               stamp += $urandom_range(2 * knobs.debounce_ms + 2);
               sample_pin(stamp, 1'($urandom_range(1)));
            end
         end else begin
            quiet_spell();
         end
      end
   endtask

   initial begin
      board = new();
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.now_ms    <= '0;
      req_if.pin_level <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= '0;
      csr_if.data      <= '0;
      knobs = board.regs;
      idling        = 1'b1;
      stamp         = '0;
      hold_off_asks = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Default windows: pending clear, press and release bounces, debounce edge
      // equality, count report and clear, hold updates, bounce back into hold.
      sample_pin(32'd0, 1'b0);
      sample_pin(32'd600, 1'b0);
      sample_pin(32'd1000, 1'b1);
      sample_pin(32'd1020, 1'b0);
      sample_pin(32'd1030, 1'b1);
      sample_pin(32'd1080, 1'b1);
      sample_pin(32'd1081, 1'b1);
      sample_pin(32'd1200, 1'b0);
      sample_pin(32'd1230, 1'b1);
      sample_pin(32'd1300, 1'b0);
      sample_pin(32'd1351, 1'b0);
      sample_pin(32'd1500, 1'b0);
      sample_pin(32'd1651, 1'b0);
      sample_pin(32'd2152, 1'b0);
      sample_pin(32'd3000, 1'b1);
      sample_pin(32'd3060, 1'b1);
      sample_pin(32'd3501, 1'b1);
      sample_pin(32'd3602, 1'b1);
      sample_pin(32'd3702, 1'b1);
      sample_pin(32'd3703, 1'b1);
      sample_pin(32'd3710, 1'b0);
      sample_pin(32'd3720, 1'b1);
      sample_pin(32'd3811, 1'b1);
      sample_pin(32'd3820, 1'b0);
      sample_pin(32'd3870, 1'b0);
      sample_pin(32'hFFFF_FFFF, 1'b0);
      settle();

      stamp = $urandom;
      random_gestures(120);
      settle();

      // Zero debounce, timeout and hold threshold windows, with the time base rolling over.
      configure(16'd0, 16'd0, 16'd0, 16'd1, 1'b0);
      stamp = 32'hFFFF_FF00;
      random_gestures(80);
      settle();

      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      stamp = $urandom;
      random_gestures(50);
      settle();

      // Random windows; stall the report side long enough to back up the input.
      configure(CFG_WIDTH'($urandom_range(100)), CFG_WIDTH'($urandom_range(600)),
                CFG_WIDTH'($urandom_range(800)), CFG_WIDTH'($urandom_range(1, 200)), 1'b1);
      hold_off_asks++;
      random_gestures(160);
      settle();

      // Tap past the press limit without ever timing out, then hold at the top count.
      configure(16'd0, 16'hFFFF, 16'd20, 16'd1, 1'b0);
      idling = 1'b0;
      repeat (MAX_PRESSES + 3) begin
         sample_pin(stamp, 1'b1);
         stamp += $urandom_range(1, 3);
         sample_pin(stamp, 1'b1);
         stamp += $urandom_range(1, 3);
         sample_pin(stamp, 1'b0);
         stamp += $urandom_range(1, 3);
         sample_pin(stamp, 1'b0);
         stamp += $urandom_range(1, 50);
      end
      sample_pin(stamp, 1'b1);
      stamp += 1;
      sample_pin(stamp, 1'b1);
      stamp += 21;
      sample_pin(stamp, 1'b1);
      repeat (3) begin
         stamp += 2;
         sample_pin(stamp, 1'b1);
      end
      stamp += 1;
      sample_pin(stamp, 1'b0);
      sample_pin(stamp, 1'b0);
      idling = 1'b1;
      settle();

      // Zero update interval: a report on every held sample that moves time.
      configure(16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0);
      sample_pin(stamp, 1'b1);
      stamp += 1;
      sample_pin(stamp, 1'b1);
      stamp += 1;
      sample_pin(stamp, 1'b1);
      repeat (40) begin
         if ($urandom_range(63) != 0) stamp += 1;
         sample_pin(stamp, 1'b1);
      end
      stamp += 1;
      sample_pin(stamp, 1'b0);
      sample_pin(stamp, 1'b0);
      settle();

      $display("%0d samples, %0d reports checked, %0d hold updates, %0d hold count wraps",
               board.samples, board.checked, board.hold_reports, board.hold_wraps);
      $display("peak press count %0d over default, zero, full-scale and random windows",
               board.peak_presses);
      if (board.mismatches == 0) begin
         $display("debounced_multi_press_detector_unit regression: pass");
      end else begin
         $display("debounced_multi_press_detector_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== debounced_multi_press_detector_unit.f =====
rtl/dmpd_pkg.sv
rtl/dmpd_if.sv
rtl/dmpd_core.sv
rtl/debounced_multi_press_detector_unit.sv
test/tb.sv
